// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/iac_pkg.sv =====
package iac_pkg;

  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;
  localparam int REG_W = 8;

  localparam logic [2:0] REG_ARM_CYCLES = 3'd0;
  localparam logic [2:0] REG_BLINK_HALF = 3'd1;
  localparam logic [2:0] REG_TRIG_WINDOW = 3'd2;
  localparam logic [2:0] REG_TRIG_TOGGLE = 3'd3;
  localparam logic [2:0] REG_SOUND_TOGGLE = 3'd4;

  localparam logic [REG_W-1:0] RST_ARM_CYCLES = 8'd10;
  localparam logic [REG_W-1:0] RST_BLINK_HALF = 8'd1;
  localparam logic [REG_W-1:0] RST_TRIG_WINDOW = 8'd20;
  localparam logic [REG_W-1:0] RST_TRIG_TOGGLE = 8'd4;
  localparam logic [REG_W-1:0] RST_SOUND_TOGGLE = 8'd2;

  localparam logic [2:0] MODE_CODE_OFF = 3'd0;
  localparam logic [2:0] MODE_CODE_ARMING = 3'd1;
  localparam logic [2:0] MODE_CODE_ARMED = 3'd2;
  localparam logic [2:0] MODE_CODE_TRIGGERED = 3'd3;
  localparam logic [2:0] MODE_CODE_SOUNDING = 3'd4;

  localparam logic [2:0] LV_NONE = 3'b000;
  localparam logic [2:0] LV_READY = 3'b001;
  localparam logic [2:0] LV_ARMED = 3'b010;
  localparam logic [2:0] LV_SIREN = 3'b100;

  typedef enum logic [4:0] {
    MODE_OFF       = 5'b00001,
    MODE_ARMING    = 5'b00010,
    MODE_ARMED     = 5'b00100,
    MODE_TRIGGERED = 5'b01000,
    MODE_SOUNDING  = 5'b10000
  } mode_t;

  typedef struct packed {
    logic [REG_W-1:0] arm_cycles;
    logic [REG_W-1:0] blink_half_ticks;
    logic [REG_W-1:0] trigger_window_ticks;
    logic [REG_W-1:0] trigger_toggle_ticks;
    logic [REG_W-1:0] sound_toggle_ticks;
  } cfg_t;

  typedef struct packed {
    logic [2:0] levels;
    logic [2:0] mode;
    logic       notify;
  } res_t;

endpackage

// ===== design/iac_regs.sv =====
`include "assert_macros.svh"

module iac_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [iac_pkg::PADDR_W-1:0]   paddr,
  input  logic [iac_pkg::PDATA_W-1:0]   pwdata,
  output logic [iac_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output iac_pkg::cfg_t                 cfg
);
  import iac_pkg::*;

  logic [2:0] index;
  logic       wr_en;
  logic [REG_W-1:0] rd_value;

  assign index = paddr[4:2];
  assign wr_en = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.arm_cycles <= RST_ARM_CYCLES;
      cfg.blink_half_ticks <= RST_BLINK_HALF;
      cfg.trigger_window_ticks <= RST_TRIG_WINDOW;
      cfg.trigger_toggle_ticks <= RST_TRIG_TOGGLE;
      cfg.sound_toggle_ticks <= RST_SOUND_TOGGLE;
    end else if (wr_en) begin
      unique case (index)
        REG_ARM_CYCLES:   cfg.arm_cycles <= pwdata[REG_W-1:0];
        REG_BLINK_HALF:   cfg.blink_half_ticks <= pwdata[REG_W-1:0];
        REG_TRIG_WINDOW:  cfg.trigger_window_ticks <= pwdata[REG_W-1:0];
        REG_TRIG_TOGGLE:  cfg.trigger_toggle_ticks <= pwdata[REG_W-1:0];
        REG_SOUND_TOGGLE: cfg.sound_toggle_ticks <= pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (index)
      REG_ARM_CYCLES:   rd_value = cfg.arm_cycles;
      REG_BLINK_HALF:   rd_value = cfg.blink_half_ticks;
      REG_TRIG_WINDOW:  rd_value = cfg.trigger_window_ticks;
      REG_TRIG_TOGGLE:  rd_value = cfg.trigger_toggle_ticks;
      REG_SOUND_TOGGLE: rd_value = cfg.sound_toggle_ticks;
      default:          rd_value = '0;
    endcase
  end

  assign prdata = PDATA_W'(rd_value);

  `ASSERT_NEXT(a_arm_write, clk, rst, wr_en && index == REG_ARM_CYCLES, cfg.arm_cycles == $past(pwdata[REG_W-1:0]))

endmodule

// ===== design/intrusion_alarm_controller.sv =====
// Channel   Direction  Handshake          Payload
// in        input      in_valid/in_ready  button_pressed, motion
// out       output     out_valid/out_ready ready_led, armed_led, siren, mode, notify
// config    input      APB write/read     psel, penable, pwrite, paddr, pwdata, prdata
//
// Each accepted request yields one result, registered in the output or the skid register.
// A request is accepted every cycle as long as the skid register is empty.
// A stalled output holds one result in the output register and one in the skid register.
// Synchronous reset sets the mode to off, clears all counters, and restores the register defaults.

`include "assert_macros.svh"

module intrusion_alarm_controller #(
  parameter int COUNT_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          button_pressed,
  input  logic                          motion,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          ready_led,
  output logic                          armed_led,
  output logic                          siren,
  output logic [2:0]                    mode,
  output logic                          notify,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [iac_pkg::PADDR_W-1:0]   paddr,
  input  logic [iac_pkg::PDATA_W-1:0]   pwdata,
  output logic [iac_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import iac_pkg::*;

  localparam int LW = (COUNT_BITS > REG_W) ? COUNT_BITS : REG_W;
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  cfg_t cfg;

  iac_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  function automatic logic [COUNT_BITS-1:0] limit_of(input logic [REG_W-1:0] r);
    logic [LW-1:0] v;
    v = LW'(r);
    if (v == '0) v = LW'(1);
    if (v > LW'(CMAX)) v = LW'(CMAX);
    return COUNT_BITS'(v);
  endfunction

  function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] c);
    return (c != CMAX) ? c + 1'b1 : c;
  endfunction

  function automatic logic [2:0] mode_code(input mode_t m);
    logic [2:0] code;
    unique case (m)
      MODE_ARMING:    code = MODE_CODE_ARMING;
      MODE_ARMED:     code = MODE_CODE_ARMED;
      MODE_TRIGGERED: code = MODE_CODE_TRIGGERED;
      MODE_SOUNDING:  code = MODE_CODE_SOUNDING;
      default:        code = MODE_CODE_OFF;
    endcase
    return code;
  endfunction

  mode_t                 alarm_mode, alarm_mode_next;
  logic [COUNT_BITS-1:0] window_count, window_count_next;
  logic [COUNT_BITS-1:0] period_count, period_count_next;
  logic [COUNT_BITS-1:0] blink_count, blink_count_next;
  logic                  toggle_phase, toggle_phase_next;
  logic [2:0]            drive_levels, drive_levels_next;
  logic                  notify_next;

  logic in_accept;
  res_t res_new;
  res_t out_res;
  res_t skid_res;
  logic skid_valid;

  assign in_ready = !skid_valid;
  assign in_accept = in_valid && in_ready;

  always_comb begin
    logic [COUNT_BITS-1:0] pc;
    logic [COUNT_BITS-1:0] wc;
    logic [COUNT_BITS-1:0] bc;
    logic                  ph;
    pc = '0;
    wc = '0;
    bc = '0;
    ph = 1'b0;
    alarm_mode_next = alarm_mode;
    window_count_next = window_count;
    period_count_next = period_count;
    blink_count_next = blink_count;
    toggle_phase_next = toggle_phase;
    drive_levels_next = drive_levels;
    notify_next = 1'b0;

    unique case (alarm_mode)
      MODE_ARMING: begin
        drive_levels_next = drive_levels & ~LV_READY;
        if (!toggle_phase) drive_levels_next = drive_levels_next | LV_READY;
        pc = bump(period_count);
        period_count_next = pc;
        if (pc >= limit_of(cfg.blink_half_ticks)) begin
          period_count_next = '0;
          if (toggle_phase) begin
            bc = bump(blink_count);
            blink_count_next = bc;
            if (bc >= limit_of(cfg.arm_cycles)) begin
              drive_levels_next = drive_levels_next | LV_ARMED;
              alarm_mode_next = MODE_ARMED;
              window_count_next = '0;
              blink_count_next = '0;
              toggle_phase_next = 1'b0;
            end else begin
              toggle_phase_next = 1'b0;
            end
          end else begin
            toggle_phase_next = 1'b1;
          end
        end
      end
      MODE_ARMED: begin
        drive_levels_next = LV_ARMED;
        if (button_pressed) begin
          alarm_mode_next = MODE_OFF;
        end else if (motion) begin
          drive_levels_next = LV_NONE;
          alarm_mode_next = MODE_TRIGGERED;
          window_count_next = '0;
          period_count_next = '0;
          blink_count_next = '0;
          toggle_phase_next = 1'b0;
        end
      end
      MODE_TRIGGERED: begin
        if (button_pressed) begin
          alarm_mode_next = MODE_OFF;
        end else begin
          pc = bump(period_count);
          period_count_next = pc;
          if (pc >= limit_of(cfg.trigger_toggle_ticks)) begin
            period_count_next = '0;
            ph = !toggle_phase;
            toggle_phase_next = ph;
            drive_levels_next = ph ? (LV_READY | LV_ARMED) : LV_NONE;
          end
          wc = bump(window_count);
          window_count_next = wc;
          if (wc >= limit_of(cfg.trigger_window_ticks)) begin
            alarm_mode_next = MODE_SOUNDING;
            notify_next = 1'b1;
            window_count_next = '0;
            period_count_next = '0;
            blink_count_next = '0;
            toggle_phase_next = 1'b0;
          end
        end
      end
      MODE_SOUNDING: begin
        if (button_pressed) begin
          alarm_mode_next = MODE_OFF;
        end else begin
          pc = bump(period_count);
          period_count_next = pc;
          if (pc >= limit_of(cfg.sound_toggle_ticks)) begin
            period_count_next = '0;
            ph = !toggle_phase;
            toggle_phase_next = ph;
            drive_levels_next = ph ? (LV_READY | LV_SIREN) : LV_ARMED;
          end
        end
      end
      default: begin
        alarm_mode_next = MODE_OFF;
        drive_levels_next = LV_READY;
        if (button_pressed) begin
          alarm_mode_next = MODE_ARMING;
          window_count_next = '0;
          period_count_next = '0;
          blink_count_next = '0;
          toggle_phase_next = 1'b0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alarm_mode <= MODE_OFF;
      window_count <= '0;
      period_count <= '0;
      blink_count <= '0;
      toggle_phase <= 1'b0;
      drive_levels <= LV_NONE;
    end else if (in_accept) begin
      alarm_mode <= alarm_mode_next;
      window_count <= window_count_next;
      period_count <= period_count_next;
      blink_count <= blink_count_next;
      toggle_phase <= toggle_phase_next;
      drive_levels <= drive_levels_next;
    end
  end

  assign res_new.levels = drive_levels_next;
  assign res_new.mode = mode_code(alarm_mode_next);
  assign res_new.notify = notify_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_accept;
      end
    end else if (in_accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (in_accept) begin
        out_res <= res_new;
      end
    end else if (in_accept) begin
      skid_res <= res_new;
    end
  end

  assign ready_led = out_res.levels[0];
  assign armed_led = out_res.levels[1];
  assign siren = out_res.levels[2];
  assign mode = out_res.mode;
  assign notify = out_res.notify;

  `ASSERT_IMP(a_skid_behind_out, clk, rst, skid_valid, out_valid)
  `ASSERT_NEXT(a_stall_to_skid, clk, rst, in_accept && out_valid && !out_ready, skid_valid)
  `ASSERT_IMP(a_notify_sounding, clk, rst, out_valid && notify, mode == MODE_CODE_SOUNDING)
  `ASSERT_NEXT(a_button_cancels, clk, rst, in_accept && button_pressed && alarm_mode == MODE_TRIGGERED, alarm_mode == MODE_OFF)

endmodule
